FILE: design/byte_stuffing_frame_encoder_defines.svh
// assertion macros for the byte stuffing frame encoder
// expects clk and rst_n in the scope of each use
`ifndef BYTE_STUFFING_FRAME_ENCODER_DEFINES_SVH
`define BYTE_STUFFING_FRAME_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define BSFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`define BSFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define BSFE_ASSERT_NEXT(lbl, ante, cons, msg)
`define BSFE_ASSERT_NOW(lbl, ante, cons, msg)
`endif
`endif

FILE: design/bsfe_pkg.sv
// shared types, codes and helpers for the byte stuffing frame encoder
// no dependencies
package bsfe_pkg;

  localparam logic [7:0] START_CODE = 8'hD8;
  localparam logic [7:0] STOP_CODE  = 8'hDA;
  localparam logic [7:0] ESC_CODE   = 8'hDA;
  localparam logic [7:0] ESC_LOW    = 8'hD8;
  localparam logic [7:0] ESC_HIGH   = 8'hDF;
  localparam logic [7:0] ESC_CLEAR  = 8'h10;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_burst;
  } out_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] sum;
    logic       first;
    logic       last;
    logic       data_special;
    logic       esc_sum;
  } job_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_DESC,
    PH_DATA,
    PH_SESC,
    PH_SUM,
    PH_STOP
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   job_wait;
  } back_stat_t;

  function automatic logic is_special(logic [7:0] b);
    return (b >= ESC_LOW) && (b <= ESC_HIGH);
  endfunction

  function automatic logic [7:0] stuff_byte(logic [7:0] b);
    return b & ~ESC_CLEAR;
  endfunction

  function automatic phase_t first_phase(job_t j);
    phase_t p;
    if (j.first) begin
      p = PH_START;
    end else if (j.data_special) begin
      p = PH_DESC;
    end else begin
      p = PH_DATA;
    end
    return p;
  endfunction

endpackage

FILE: design/bsfe_front.sv
// front end: accepts requests, keeps the running checksum, builds jobs
// depends on bsfe_pkg
module bsfe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bsfe_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output bsfe_pkg::job_t    q_job
);

  logic [7:0] sum_r;
  logic [7:0] sum_nxt;
  logic [7:0] base;
  logic [7:0] contrib;
  logic       data_special;

  assign q_push       = push && !q_full;
  assign data_special = bsfe_pkg::is_special(in_data.data_byte);
  assign base         = in_data.first_byte ? 8'h00 : sum_r;
  assign contrib      = data_special ?
                        8'(bsfe_pkg::ESC_CODE + bsfe_pkg::stuff_byte(in_data.data_byte)) :
                        in_data.data_byte;
  assign sum_nxt      = 8'(base + contrib);

  always_comb begin
    q_job.data         = in_data.data_byte;
    q_job.sum          = sum_nxt;
    q_job.first        = in_data.first_byte;
    q_job.last         = in_data.last_byte;
    q_job.data_special = data_special;
    q_job.esc_sum      = bsfe_pkg::is_special(sum_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= 8'h00;
    end else if (q_push) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

FILE: design/bsfe_fifo.sv
// short job queue between front and back end
// depends on bsfe_pkg
module bsfe_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  bsfe_pkg::job_t wr_job,
  output logic           full,
  input  logic           rd_en,
  output bsfe_pkg::job_t rd_job,
  output logic           empty
);

  bsfe_pkg::job_t                mem_r [bsfe_pkg::QDEPTH];
  logic [bsfe_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [bsfe_pkg::QPTR_W-1:0]   wr_ptr_nxt;
  logic [bsfe_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [bsfe_pkg::QPTR_W-1:0]   rd_ptr_nxt;
  logic [bsfe_pkg::QPTR_W:0]     count_r;
  logic [bsfe_pkg::QPTR_W:0]     count_nxt;
  logic                          do_wr;
  logic                          do_rd;

  assign full   = (count_r == (bsfe_pkg::QPTR_W+1)'(bsfe_pkg::QDEPTH));
  assign empty  = (count_r == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_wr && do_rd) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: design/bsfe_back.sv
// back end: sequences the framed bytes of each job into the output register
// depends on bsfe_pkg
module bsfe_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bsfe_pkg::job_t       q_job,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  logic                 pop,
  output logic                 empty,
  output bsfe_pkg::out_item_t  out_data,
  output bsfe_pkg::back_stat_t stat
);

  bsfe_pkg::phase_t    phase_r;
  bsfe_pkg::phase_t    phase_nxt;
  bsfe_pkg::job_t      job_r;
  bsfe_pkg::job_t      job_nxt;
  logic                out_v_r;
  logic                out_v_nxt;
  bsfe_pkg::out_item_t out_r;
  bsfe_pkg::out_item_t out_nxt;
  logic                adv;
  logic                done_here;
  logic                load;
  logic [7:0]          emit_byte;
  logic                emit_eob;

  assign adv       = (phase_r != bsfe_pkg::PH_IDLE) && (!out_v_r || pop);
  assign done_here = ((phase_r == bsfe_pkg::PH_DATA) && !job_r.last) ||
                     (phase_r == bsfe_pkg::PH_STOP);
  assign load      = (phase_r == bsfe_pkg::PH_IDLE) || (adv && done_here);
  assign q_pop     = load && !q_empty;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      bsfe_pkg::PH_IDLE: begin
        if (!q_empty) begin
          phase_nxt = bsfe_pkg::first_phase(q_job);
        end
      end
      bsfe_pkg::PH_START: begin
        if (adv) begin
          phase_nxt = job_r.data_special ? bsfe_pkg::PH_DESC : bsfe_pkg::PH_DATA;
        end
      end
      bsfe_pkg::PH_DESC: begin
        if (adv) begin
          phase_nxt = bsfe_pkg::PH_DATA;
        end
      end
      bsfe_pkg::PH_DATA: begin
        if (adv) begin
          if (job_r.last) begin
            phase_nxt = job_r.esc_sum ? bsfe_pkg::PH_SESC : bsfe_pkg::PH_SUM;
          end else begin
            phase_nxt = q_empty ? bsfe_pkg::PH_IDLE : bsfe_pkg::first_phase(q_job);
          end
        end
      end
      bsfe_pkg::PH_SESC: begin
        if (adv) begin
          phase_nxt = bsfe_pkg::PH_SUM;
        end
      end
      bsfe_pkg::PH_SUM: begin
        if (adv) begin
          phase_nxt = bsfe_pkg::PH_STOP;
        end
      end
      bsfe_pkg::PH_STOP: begin
        if (adv) begin
          phase_nxt = q_empty ? bsfe_pkg::PH_IDLE : bsfe_pkg::first_phase(q_job);
        end
      end
      default: begin
        phase_nxt = bsfe_pkg::PH_IDLE;
      end
    endcase
  end

  // byte per phase
  always_comb begin
    emit_byte = bsfe_pkg::STOP_CODE;
    emit_eob  = 1'b0;
    case (phase_r)
      bsfe_pkg::PH_START: begin
        emit_byte = bsfe_pkg::START_CODE;
      end
      bsfe_pkg::PH_DESC: begin
        emit_byte = bsfe_pkg::ESC_CODE;
      end
      bsfe_pkg::PH_DATA: begin
        emit_byte = job_r.data_special ? bsfe_pkg::stuff_byte(job_r.data) : job_r.data;
        emit_eob  = !job_r.last;
      end
      bsfe_pkg::PH_SESC: begin
        emit_byte = bsfe_pkg::ESC_CODE;
      end
      bsfe_pkg::PH_SUM: begin
        emit_byte = job_r.esc_sum ? bsfe_pkg::stuff_byte(job_r.sum) : job_r.sum;
      end
      bsfe_pkg::PH_STOP: begin
        emit_byte = bsfe_pkg::STOP_CODE;
        emit_eob  = 1'b1;
      end
      default: begin
        emit_byte = bsfe_pkg::STOP_CODE;
        emit_eob  = 1'b0;
      end
    endcase
  end

  always_comb begin
    job_nxt   = q_pop ? q_job : job_r;
    out_v_nxt = out_v_r;
    out_nxt   = out_r;
    if (adv) begin
      out_v_nxt            = 1'b1;
      out_nxt.out_byte     = emit_byte;
      out_nxt.end_of_burst = emit_eob;
    end else if (pop) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bsfe_pkg::PH_IDLE;
      out_v_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign empty         = !out_v_r;
  assign out_data      = out_r;
  assign stat.phase    = phase_r;
  assign stat.job_wait = !q_empty;

endmodule

FILE: design/byte_stuffing_frame_encoder.sv
// byte stuffing frame encoder: front end, job queue, byte sequencer
// a request passes the queue, the sequencer job register and the output byte register
// throughput: one result per cycle unless pop is low; a request makes 1 to 6 results,
// paced by the single output byte register of the sequencer
// reset (synchronous, rst_n low) clears the checksum, the queue and the sequencer
// depends on bsfe_pkg, bsfe_front, bsfe_fifo, bsfe_back
`include "byte_stuffing_frame_encoder_defines.svh"
module byte_stuffing_frame_encoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  bsfe_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output bsfe_pkg::out_item_t out_data
);

  logic                 q_push;
  logic                 q_pop;
  logic                 q_empty;
  logic                 back_idle;
  bsfe_pkg::job_t       wr_job;
  bsfe_pkg::job_t       rd_job;
  bsfe_pkg::back_stat_t stat;

  bsfe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .q_full  (full),
    .q_push  (q_push),
    .q_job   (wr_job)
  );

  bsfe_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_push),
    .wr_job (wr_job),
    .full   (full),
    .rd_en  (q_pop),
    .rd_job (rd_job),
    .empty  (q_empty)
  );

  bsfe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_job    (rd_job),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data),
    .stat     (stat)
  );

  assign back_idle = (stat.phase == bsfe_pkg::PH_IDLE);

  `BSFE_ASSERT_NEXT(a_accept_fills_queue, q_push, !q_empty || !back_idle, "request lost")
  `BSFE_ASSERT_NEXT(a_idle_picks_job, back_idle && stat.job_wait, !back_idle, "job waiting")
  `BSFE_ASSERT_NOW(a_pop_only_on_load, q_pop, !q_empty, "queue read while empty")

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for byte_stuffing_frame_encoder: directed table, then random frames
// framed bytes are predicted per request and checked in order on the result queue
// depends on bsfe_pkg and the encoder rtl
`timescale 1ns / 100ps
module tb_top;

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [2:0]  n_lit;
    logic [47:0] lit;
  } stim_row_t;

  localparam int NUM_ROWS = 20;
  localparam int RANDOM_REQUESTS = 90;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                pop = 1'b0;
  logic                full;
  logic                empty;
  bsfe_pkg::in_item_t  in_data = '0;
  bsfe_pkg::out_item_t out_data;

  logic                calm = 1'b0;
  logic [7:0]          frame_sum = '0;
  logic [7:0]          burst_bytes [$];
  bsfe_pkg::out_item_t framed_bytes_q [$];
  bsfe_pkg::out_item_t head_result;
  int                  mismatch_count = 0;
  stim_row_t           stim_table [NUM_ROWS];

  byte_stuffing_frame_encoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic stim_row_t make_row(logic [7:0] data, logic first, logic last,
                                         logic [2:0] n_lit, logic [47:0] lit);
    stim_row_t row;
    row.data = data;
    row.first = first;
    row.last = last;
    row.n_lit = n_lit;
    row.lit = lit;
    return row;
  endfunction

  // appends one byte with escaping, returns what it adds to the sum
  function automatic logic [7:0] stuff_into_burst(logic [7:0] b);
    logic [7:0] masked;
    masked = b & ~bsfe_pkg::ESC_CLEAR;
    if (b >= bsfe_pkg::ESC_LOW && b <= bsfe_pkg::ESC_HIGH) begin
      burst_bytes.push_back(bsfe_pkg::ESC_CODE);
      burst_bytes.push_back(masked);
      return bsfe_pkg::ESC_CODE + masked;
    end
    burst_bytes.push_back(b);
    return b;
  endfunction

  function automatic void encode_request(bsfe_pkg::in_item_t r);
    burst_bytes.delete();
    if (r.first_byte) begin
      frame_sum = '0;
      burst_bytes.push_back(bsfe_pkg::START_CODE);
    end
    frame_sum = frame_sum + stuff_into_burst(r.data_byte);
    if (r.last_byte) begin
      void'(stuff_into_burst(frame_sum));
      burst_bytes.push_back(bsfe_pkg::STOP_CODE);
    end
  endfunction

  function automatic void expect_request(bsfe_pkg::in_item_t r, logic [2:0] n_lit,
                                         logic [47:0] lit);
    bsfe_pkg::out_item_t e;
    encode_request(r);
    if (n_lit != 0) begin
      burst_bytes.delete();
      for (int k = 0; k < n_lit; k++) burst_bytes.push_back(lit[47 - 8 * k -: 8]);
    end
    foreach (burst_bytes[k]) begin
      e.out_byte = burst_bytes[k];
      e.end_of_burst = (k == burst_bytes.size() - 1);
      framed_bytes_q.push_back(e);
    end
  endfunction

  function automatic logic [7:0] rand_payload();
    if ($urandom_range(0, 99) < 30) begin
      return 8'($urandom_range(bsfe_pkg::ESC_LOW, bsfe_pkg::ESC_HIGH));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // entered and left at a falling edge; push stays high between back-to-back requests
  task automatic send_request(input bsfe_pkg::in_item_t r, input logic [2:0] n_lit,
                              input logic [47:0] lit);
    while (!calm && $urandom_range(0, 99) < 28) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    expect_request(r, n_lit, lit);
    @(negedge clk);
  endtask

  initial begin
    bsfe_pkg::in_item_t r;
    int items;
    int len;
    stim_table[0]  = make_row(8'h00, 1'b0, 1'b0, 3'd1, {8'h00, 40'h0});
    stim_table[1]  = make_row(8'hFF, 1'b1, 1'b1, 3'd4,
                              {bsfe_pkg::START_CODE, 8'hFF, 8'hFF, bsfe_pkg::STOP_CODE,
                               16'h0});
    stim_table[2]  = make_row(8'h01, 1'b0, 1'b0, 3'd0, '0);
    stim_table[3]  = make_row(8'hD8, 1'b1, 1'b0, 3'd3,
                              {bsfe_pkg::START_CODE, bsfe_pkg::ESC_CODE, 8'hC8, 24'h0});
    stim_table[4]  = make_row(8'hD9, 1'b0, 1'b0, 3'd0, '0);
    stim_table[5]  = make_row(8'hDA, 1'b0, 1'b0, 3'd0, '0);
    stim_table[6]  = make_row(8'hDB, 1'b0, 1'b0, 3'd0, '0);
    stim_table[7]  = make_row(8'hDC, 1'b0, 1'b0, 3'd0, '0);
    stim_table[8]  = make_row(8'hDD, 1'b0, 1'b0, 3'd0, '0);
    stim_table[9]  = make_row(8'hDE, 1'b0, 1'b0, 3'd0, '0);
    stim_table[10] = make_row(8'hDF, 1'b0, 1'b0, 3'd0, '0);
    stim_table[11] = make_row(8'hD7, 1'b0, 1'b0, 3'd0, '0);
    stim_table[12] = make_row(8'hE0, 1'b0, 1'b1, 3'd0, '0);
    stim_table[13] = make_row(8'h80, 1'b0, 1'b0, 3'd0, '0);
    stim_table[14] = make_row(8'h55, 1'b1, 1'b0, 3'd0, '0);
    stim_table[15] = make_row(8'hAA, 1'b1, 1'b0, 3'd0, '0);
    stim_table[16] = make_row(8'h3C, 1'b0, 1'b1, 3'd0, '0);
    stim_table[17] = make_row(8'h60, 1'b1, 1'b0, 3'd2,
                              {bsfe_pkg::START_CODE, 8'h60, 32'h0});
    stim_table[18] = make_row(8'h7C, 1'b0, 1'b1, 3'd4,
                              {8'h7C, bsfe_pkg::ESC_CODE, 8'hCC, bsfe_pkg::STOP_CODE,
                               16'h0});
    stim_table[19] = make_row(8'hD8, 1'b1, 1'b1, 3'd0, '0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      r.data_byte = stim_table[i].data;
      r.first_byte = stim_table[i].first;
      r.last_byte = stim_table[i].last;
      send_request(r, stim_table[i].n_lit, stim_table[i].lit);
    end

    items = 0;
    while (items < RANDOM_REQUESTS) begin
      calm = (items >= 40 && items < 70);
      if ($urandom_range(0, 99) < 15) begin
        r.data_byte = rand_payload();
        r.first_byte = 1'($urandom_range(0, 1));
        r.last_byte = 1'($urandom_range(0, 1));
        send_request(r, 3'd0, '0);
        items++;
      end else begin
        len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
        for (int k = 0; k < len; k++) begin
          r.data_byte = rand_payload();
          r.first_byte = (k == 0);
          r.last_byte = (k == len - 1);
          send_request(r, 3'd0, '0);
          items++;
        end
      end
    end
    calm = 1'b0;
    push <= 1'b0;

    while (framed_bytes_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  always @(negedge clk) begin
    pop <= calm ? 1'b1 : ($urandom_range(0, 99) >= 28);
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (framed_bytes_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual byte %h end %b",
                 $time, out_data.out_byte, out_data.end_of_burst);
        mismatch_count++;
      end else begin
        head_result = framed_bytes_q.pop_front();
        if (head_result.out_byte !== out_data.out_byte) begin
          $display("%0t: out_byte mismatch: expected %h actual %h",
                   $time, head_result.out_byte, out_data.out_byte);
          mismatch_count++;
        end
        if (head_result.end_of_burst !== out_data.end_of_burst) begin
          $display("%0t: end_of_burst mismatch: expected %b actual %b",
                   $time, head_result.end_of_burst, out_data.end_of_burst);
          mismatch_count++;
        end
      end
    end
  end

endmodule

FILE: sim.f
+incdir+design
design/bsfe_pkg.sv
design/bsfe_front.sv
design/bsfe_fifo.sv
design/bsfe_back.sv
design/byte_stuffing_frame_encoder.sv
tb/tb_top.sv
